[src/cc20_pkg.sv]
// ============================================================================
// cc20_pkg: shared types and constants for the ChaCha20 stream cipher
// Holds the beat payload structs, register indexes and the quarter round.
// ============================================================================
package cc20_pkg;

	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646e;
	localparam logic [31:0] SIGMA2 = 32'h79622d32;
	localparam logic [31:0] SIGMA3 = 32'h6b206574;

	localparam logic [2:0] REG_KEY_0         = 3'd0;
	localparam logic [2:0] REG_KEY_1         = 3'd1;
	localparam logic [2:0] REG_KEY_2         = 3'd2;
	localparam logic [2:0] REG_KEY_3         = 3'd3;
	localparam logic [2:0] REG_NONCE_LOW     = 3'd4;
	localparam logic [2:0] REG_NONCE_HIGH    = 3'd5;
	localparam logic [2:0] REG_START_COUNTER = 3'd6;

	typedef struct packed {
		logic [63:0] data_in;
		logic [3:0]  byte_count;
		logic        last_of_message;
	} in_beat_t;

	typedef struct packed {
		logic [63:0] data_out;
		logic [3:0]  byte_count_out;
		logic        last_out;
	} out_beat_t;

	// Work item handed from the front end to the keystream back end.
	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  count;
		logic        last;
		logic        new_block;
		logic [2:0]  word;
	} job_t;

	typedef logic [15:0][31:0] cc_state_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction

	// One ChaCha quarter round on four words, returned packed a,b,c,d.
	function automatic logic [127:0] quarter(input logic [31:0] a, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] ta, tb, tc, td;
		ta = a + b; td = rotl(d ^ ta, 16);
		tc = c + td; tb = rotl(b ^ tc, 12);
		ta = ta + tb; td = rotl(td ^ ta, 8);
		tc = tc + td; tb = rotl(tb ^ tc, 7);
		quarter = {ta, tb, tc, td};
	endfunction

endpackage

[src/cc20_front.sv]
// ============================================================================
// cc20_front: input acceptance and block classification
// Tracks the word position and tags each beat with its keystream word slot.
// ============================================================================
module cc20_front import cc20_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  in_beat_t in_beat,
	input  logic     in_valid,
	output logic     in_ready,
	output job_t     job,
	output logic     job_valid,
	input  logic     job_ready
);

	logic [2:0] word_q;
	logic [3:0] cnt;

	assign in_ready  = job_ready;
	assign job_valid = in_valid;

	// Clamp the byte count and tag the beat.
	always_comb begin
		cnt = (in_beat.byte_count > 4'd8) ? 4'd8 : in_beat.byte_count;
		job.data      = in_beat.data_in;
		job.count     = cnt;
		job.last      = in_beat.last_of_message;
		job.new_block = (word_q == 3'd0);
		job.word      = word_q;
	end

	// Word position: the last beat of a message restarts at a fresh block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= 3'd0;
		end else if (in_valid && job_ready) begin
			word_q <= in_beat.last_of_message ? 3'd0 : word_q + 3'd1;
		end
	end

endmodule

[src/cc20_fifo.sv]
// ============================================================================
// cc20_fifo: short job queue between the front and back ends
// Two-entry queue that decouples the two halves' stalls.
// ============================================================================
module cc20_fifo import cc20_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  job_t wr_job,
	input  logic wr_valid,
	output logic wr_ready,
	output job_t rd_job,
	output logic rd_valid,
	input  logic rd_ready
);

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr_en, rd_en;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_job   = mem_q[rp_q];
	assign wr_en    = wr_valid && wr_ready;
	assign rd_en    = rd_valid && rd_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_job;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (rd_en) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("job queue over full");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("job queue count did not rise");
	a_empty_read: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !rd_en) else $error("read from empty queue");
`endif

endmodule

[src/cc20_back.sv]
// ============================================================================
// cc20_back: keystream generation and data XOR
// Runs one double round per cycle on a new block, then XORs words.
// ============================================================================
module cc20_back import cc20_pkg::*; #(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [255:0] key,
	input  logic [95:0]  nonce,
	input  logic         ctr_load,
	input  logic [31:0]  ctr_value,
	input  job_t       job,
	input  logic       job_valid,
	output logic       job_ready,
	output out_beat_t  out_beat,
	output logic       out_valid,
	input  logic       out_ready
);

	localparam int RW = $clog2(DOUBLE_ROUNDS + 1);

	cc_state_t       init_q, x_q, xn;
	logic [63:0]     ks_q [8];
	logic [31:0]     ctr_q;
	logic            busy_q;
	logic [RW-1:0]   round_q;
	logic            out_free, take, start;
	logic            done_q, take2;
	logic [63:0]     mask, ksw;
	logic [127:0]    q0, q1, q2, q3, q4, q5, q6, q7;
	cc_state_t       c;

	assign out_free  = !out_valid || out_ready;
	// A block is started once per opening beat; a finished block waits for its beat.
	assign start     = job_valid && job.new_block && !busy_q && !done_q && !(round_q != '0);
	// A job proceeds when its block is ready and the output register is free.
	assign take      = job_valid && out_free && !busy_q && !job.new_block;
	assign job_ready = take || take2;

	// One double round: columns then diagonals.
	always_comb begin
		q0 = quarter(x_q[0], x_q[4], x_q[8],  x_q[12]);
		q1 = quarter(x_q[1], x_q[5], x_q[9],  x_q[13]);
		q2 = quarter(x_q[2], x_q[6], x_q[10], x_q[14]);
		q3 = quarter(x_q[3], x_q[7], x_q[11], x_q[15]);
		c[0] = q0[127:96]; c[4] = q0[95:64]; c[8]  = q0[63:32]; c[12] = q0[31:0];
		c[1] = q1[127:96]; c[5] = q1[95:64]; c[9]  = q1[63:32]; c[13] = q1[31:0];
		c[2] = q2[127:96]; c[6] = q2[95:64]; c[10] = q2[63:32]; c[14] = q2[31:0];
		c[3] = q3[127:96]; c[7] = q3[95:64]; c[11] = q3[63:32]; c[15] = q3[31:0];
		q4 = quarter(c[0], c[5], c[10], c[15]);
		q5 = quarter(c[1], c[6], c[11], c[12]);
		q6 = quarter(c[2], c[7], c[8],  c[13]);
		q7 = quarter(c[3], c[4], c[9],  c[14]);
		xn[0] = q4[127:96]; xn[5] = q4[95:64]; xn[10] = q4[63:32]; xn[15] = q4[31:0];
		xn[1] = q5[127:96]; xn[6] = q5[95:64]; xn[11] = q5[63:32]; xn[12] = q5[31:0];
		xn[2] = q6[127:96]; xn[7] = q6[95:64]; xn[8]  = q6[63:32]; xn[13] = q6[31:0];
		xn[3] = q7[127:96]; xn[4] = q7[95:64]; xn[9]  = q7[63:32]; xn[14] = q7[31:0];
	end

	// Block engine control and running counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			round_q <= '0;
			ctr_q   <= 32'd0;
		end else begin
			if (ctr_load) begin
				ctr_q <= ctr_value;
			end else if (start) begin
				ctr_q <= ctr_q + 32'd1;
			end
			if (start) begin
				busy_q  <= 1'b1;
				round_q <= RW'(DOUBLE_ROUNDS);
			end else if (busy_q) begin
				round_q <= round_q - RW'(1);
				if (round_q == RW'(1)) busy_q <= 1'b0;
			end
		end
	end

	// Round state and finished keystream words.
	always_ff @(posedge clk) begin
		if (start) begin
			init_q <= {nonce[95:64], nonce[63:32], nonce[31:0], ctr_q, key[255:224],
				key[223:192], key[191:160], key[159:128], key[127:96], key[95:64],
				key[63:32], key[31:0], SIGMA3, SIGMA2, SIGMA1, SIGMA0};
			x_q <= {nonce[95:64], nonce[63:32], nonce[31:0], ctr_q, key[255:224],
				key[223:192], key[191:160], key[159:128], key[127:96], key[95:64],
				key[63:32], key[31:0], SIGMA3, SIGMA2, SIGMA1, SIGMA0};
		end else if (busy_q) begin
			x_q <= xn;
			if (round_q == RW'(1)) begin
				for (int j = 0; j < 8; j++) begin
					ks_q[j] <= {xn[2*j+1] + init_q[2*j+1], xn[2*j] + init_q[2*j]};
				end
			end
		end
	end

	// The done flag is set once the block is made and cleared when its opening beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (busy_q && round_q == RW'(1)) begin
			done_q <= 1'b1;
		end else if (take2) begin
			done_q <= 1'b0;
		end
	end

	assign take2 = job_valid && out_free && !busy_q && job.new_block && done_q;

	// XOR and output register.
	always_comb begin
		ksw  = ks_q[job.word];
		mask = (job.count >= 4'd8) ? '1 : ((64'd1 << {job.count[2:0], 3'b000}) - 64'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take || take2) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take || take2) begin
			out_beat.data_out       <= (job.data ^ ksw) & mask;
			out_beat.byte_count_out <= job.count;
			out_beat.last_out       <= job.last;
		end
	end

`ifndef ASSERT_OFF
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !(take || take2)) else $error("beat taken during block make");
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && round_q == RW'(1)) |=> !busy_q) else $error("round count overrun");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q) else $error("block start lost");
`endif

endmodule

[src/chacha20_stream_cipher.sv]
// Path: a beat inside a block passes the job queue and the output register; a beat
// opening a block also waits for the round engine (one double round per cycle).
// Throughput: one beat per cycle within a block while the output is not stalled; a
// beat opening a block holds the back end until its block is made.
// Reset: asynchronous, active low; clears counter, word position and queue.
// Keystream words are undefined until the first block is made.
// ============================================================================
// chacha20_stream_cipher: ChaCha20 encrypt and decrypt, 8 bytes per beat
// Front end tags beats, a queue decouples it from the keystream back end.
// ============================================================================
module chacha20_stream_cipher import cc20_pkg::*; #(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  in_beat_t    in_beat,
	input  logic        in_valid,
	output logic        in_ready,
	output out_beat_t   out_beat,
	output logic        out_valid,
	input  logic        out_ready
);

	logic [63:0] key0_q, key1_q, key2_q, key3_q, nlo_q;
	logic [31:0] nhi_q;
	job_t        f_job, b_job;
	logic        f_valid, f_ready, b_valid, b_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= '0; key1_q <= '0; key2_q <= '0; key3_q <= '0;
			nlo_q <= '0; nhi_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_0:      key0_q <= cfg_data;
				REG_KEY_1:      key1_q <= cfg_data;
				REG_KEY_2:      key2_q <= cfg_data;
				REG_KEY_3:      key3_q <= cfg_data;
				REG_NONCE_LOW:  nlo_q  <= cfg_data;
				REG_NONCE_HIGH: nhi_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	cc20_front u_front (
		.clk, .arst_n, .in_beat, .in_valid, .in_ready,
		.job(f_job), .job_valid(f_valid), .job_ready(f_ready)
	);

	cc20_fifo u_fifo (
		.clk, .arst_n, .wr_job(f_job), .wr_valid(f_valid), .wr_ready(f_ready),
		.rd_job(b_job), .rd_valid(b_valid), .rd_ready(b_ready)
	);

	cc20_back #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_back (
		.clk, .arst_n,
		.key({key3_q, key2_q, key1_q, key0_q}),
		.nonce({nhi_q, nlo_q}),
		.ctr_load(cfg_we && cfg_index == REG_START_COUNTER),
		.ctr_value(cfg_data[31:0]),
		.job(b_job), .job_valid(b_valid), .job_ready(b_ready),
		.out_beat, .out_valid, .out_ready
	);

endmodule
